/* src/button_press_doublepress_hold_detector_core_defines.svh */
// Assertion macros used by the detector core RTL.
`ifndef BUTTON_PRESS_DOUBLEPRESS_HOLD_DETECTOR_CORE_DEFINES_SVH
`define BUTTON_PRESS_DOUBLEPRESS_HOLD_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BPDH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bpdh assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BPDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bpdh assertion failed");

`endif

/* src/bpdh_pkg.sv */
package bpdh_pkg;

	localparam int unsigned CNT_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TDATA_W = 8;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_PRESS  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_HOLD   = 2'd3
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_MIN = 2'd0,
		CFG_HOLD      = 2'd1,
		CFG_WINDOW    = 2'd2
	} cfg_idx_t;

	localparam logic [CNT_W-1:0] PRESS_MIN_RST = 8'd1;
	localparam logic [CNT_W-1:0] HOLD_RST      = 8'd20;
	localparam logic [CNT_W-1:0] WINDOW_RST    = 8'd5;

	typedef struct packed {
		logic [CNT_W-1:0] press_min_ticks;
		logic [CNT_W-1:0] hold_ticks;
		logic [CNT_W-1:0] double_window_ticks;
	} cfg_t;

	typedef struct packed {
		logic enable;
		logic button_level;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] press_count;
		logic [CNT_W-1:0] gap_count;
		logic [CNT_W-1:0] gap_snapshot;
		logic             hold_seen;
		ev_t              last_event;
	} state_t;

endpackage

/* src/bpdh_cfg.sv */
module bpdh_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpdh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpdh_pkg::CNT_W-1:0]        cfg_data,
	output bpdh_pkg::cfg_t                    cfg
);

	bpdh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_min_ticks     <= bpdh_pkg::PRESS_MIN_RST;
			cfg_q.hold_ticks          <= bpdh_pkg::HOLD_RST;
			cfg_q.double_window_ticks <= bpdh_pkg::WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpdh_pkg::CFG_PRESS_MIN: cfg_q.press_min_ticks     <= cfg_data;
				bpdh_pkg::CFG_HOLD:      cfg_q.hold_ticks          <= cfg_data;
				bpdh_pkg::CFG_WINDOW:    cfg_q.double_window_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/bpdh_detect.sv */
module bpdh_detect (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  bpdh_pkg::item_t  item,
	input  bpdh_pkg::cfg_t   cfg,
	output bpdh_pkg::ev_t    code,
	output bpdh_pkg::state_t st
);

	bpdh_pkg::state_t st_q;
	bpdh_pkg::state_t st_nxt;
	logic [bpdh_pkg::CNT_W-1:0] pc_inc;
	logic [bpdh_pkg::CNT_W-1:0] gc_inc;

	assign pc_inc = st_q.press_count + 8'd1;
	assign gc_inc = st_q.gap_count + 8'd1;

	always_comb begin
		st_nxt = st_q;
		code   = bpdh_pkg::EV_NONE;
		if (item.enable) begin
			if (item.button_level) begin
				st_nxt.gap_snapshot = '0;
				if (pc_inc > cfg.hold_ticks) begin
					st_nxt.hold_seen   = 1'b1;
					st_nxt.gap_count   = '0;
					st_nxt.press_count = '0;
					st_nxt.last_event  = bpdh_pkg::EV_HOLD;
				end else begin
					st_nxt.press_count = pc_inc;
				end
			end else if (st_q.press_count > cfg.press_min_ticks && !st_q.hold_seen) begin
				// A press that differs from the snapshot means a new press came within the window.
				if (gc_inc > cfg.double_window_ticks) begin
					st_nxt.press_count = '0;
					st_nxt.gap_count   = '0;
					st_nxt.last_event  = bpdh_pkg::EV_PRESS;
				end else if (gc_inc > 8'd1 && st_q.gap_snapshot != st_q.press_count) begin
					st_nxt.press_count = '0;
					st_nxt.gap_count   = '0;
					st_nxt.last_event  = bpdh_pkg::EV_DOUBLE;
				end else begin
					st_nxt.gap_count = gc_inc;
				end
				st_nxt.gap_snapshot = st_nxt.press_count;
			end else begin
				st_nxt.press_count  = '0;
				st_nxt.gap_count    = '0;
				st_nxt.gap_snapshot = '0;
				st_nxt.hold_seen    = 1'b0;
			end
			code = st_nxt.last_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.press_count  <= '0;
			st_q.gap_count    <= '0;
			st_q.gap_snapshot <= '0;
			st_q.hold_seen    <= 1'b0;
			st_q.last_event   <= bpdh_pkg::EV_NONE;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

	assign st = st_q;

endmodule

/* src/button_press_doublepress_hold_detector_core.sv */
// Button click, double click and long press detector. One request carries one
// sampled button level and an enable bit; each request gives exactly one
// result with the event code (0 none, 1 press, 2 double press, 3 hold). The
// last event is sticky and is reported on every enabled request; a disabled
// request reports 0 and leaves the detector state untouched. A request passes
// an input register and a result register. Its result is computed from the
// input register and offered from the result register. A new request is
// taken every cycle as long as the result side keeps up. The counter update
// is a single compare-and-increment step between those two registers.
// Thresholds are to be written through the configuration port by the user
// only while no request is in flight; the block does not enforce this.
`include "button_press_doublepress_hold_detector_core_defines.svh"

module button_press_doublepress_hold_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bpdh_pkg::TDATA_W-1:0]        s_axis_tdata,  // [0] button_level, [1] enable
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bpdh_pkg::TDATA_W-1:0]        m_axis_tdata,  // [1:0] event_code
	input  logic                                cfg_we,
	input  logic [bpdh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpdh_pkg::CNT_W-1:0]          cfg_data
);

	logic             valid_s1;
	bpdh_pkg::item_t  item_s1;
	logic             valid_s2;
	bpdh_pkg::ev_t    code_s2;
	logic             advance;
	bpdh_pkg::cfg_t   cfg;
	bpdh_pkg::ev_t    code;
	bpdh_pkg::state_t st;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.button_level <= s_axis_tdata[0];
			item_s1.enable       <= s_axis_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_s2 <= code;
		end
	end

	bpdh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpdh_detect u_detect (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.code   (code),
		.st     (st)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, code_s2};

	`BPDH_ASSERT_NEXT(a_frozen_when_disabled, clk, arst_n, advance && !item_s1.enable, $stable(st))
	`BPDH_ASSERT_NEXT(a_result_is_last_event, clk, arst_n, advance && item_s1.enable,
		m_axis_tdata[1:0] == st.last_event)
	`BPDH_ASSERT_SAME(a_ready_when_out_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

/* tb/bpdh_event_checker.sv */
module bpdh_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bpdh_pkg::TDATA_W-1:0]   s_axis_tdata,  // [0] button_level, [1] enable
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bpdh_pkg::TDATA_W-1:0]   m_axis_tdata,  // [1:0] event_code
	input  logic                           cfg_we,
	input  logic [bpdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpdh_pkg::CNT_W-1:0]     cfg_data,
	output int                             mismatches,
	output int                             awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import bpdh_pkg::*;

	logic [CNT_W-1:0] min_press;
	logic [CNT_W-1:0] hold_limit;
	logic [CNT_W-1:0] window_len;

	logic [CNT_W-1:0] press_cnt;
	logic [CNT_W-1:0] gap_cnt;
	logic [CNT_W-1:0] gap_snap;
	logic             hold_mark;
	ev_t              sticky_ev;

	ev_t expected_events[$];

	// Advances the detector by one request and returns the code it reports.
	function automatic ev_t step_detector(item_t req);
		if (!req.enable) begin
			return EV_NONE;
		end
		if (req.button_level) begin
			press_cnt = press_cnt + 1'b1;
			gap_snap = '0;
			if (press_cnt > hold_limit) begin
				hold_mark = 1'b1;
				gap_cnt = '0;
				press_cnt = '0;
				sticky_ev = EV_HOLD;
			end
		end else if (press_cnt > min_press && !hold_mark) begin
			gap_cnt = gap_cnt + 1'b1;
			if (gap_cnt > window_len) begin
				press_cnt = '0;
				gap_cnt = '0;
				sticky_ev = EV_PRESS;
			end else if (gap_cnt > 8'd1 && gap_snap != press_cnt) begin
				// The snapshot was cleared by a press after the first release tick.
				press_cnt = '0;
				gap_cnt = '0;
				sticky_ev = EV_DOUBLE;
			end
			gap_snap = press_cnt;
		end else begin
			// A press that was too short, or the release after a hold.
			gap_cnt = '0;
			press_cnt = '0;
			gap_snap = '0;
			hold_mark = 1'b0;
		end
		return sticky_ev;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ev_t want;
		if (!arst_n) begin
			min_press = PRESS_MIN_RST;
			hold_limit = HOLD_RST;
			window_len = WINDOW_RST;
			press_cnt = '0;
			gap_cnt = '0;
			gap_snap = '0;
			hold_mark = 1'b0;
			sticky_ev = EV_NONE;
			expected_events.delete();
			mismatches = 0;
			awaiting = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					note_mismatch("result with no request pending", int'(m_axis_tdata), -1);
				end else begin
					want = expected_events.pop_front();
					if (m_axis_tdata[1:0] != want) begin
						note_mismatch("event_code", int'(m_axis_tdata[1:0]), int'(want));
					end
					if (m_axis_tdata[TDATA_W-1:2] != '0) begin
						note_mismatch("tdata padding", int'(m_axis_tdata[TDATA_W-1:2]), 0);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_events.push_back(step_detector(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PRESS_MIN: begin
						min_press = cfg_data;
					end
					CFG_HOLD: begin
						hold_limit = cfg_data;
					end
					CFG_WINDOW: begin
						window_len = cfg_data;
					end
					default: begin
					end
				endcase
			end
			awaiting = expected_events.size();
		end
	end

endmodule

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpdh_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int STALL_CYCLES = 64;
	localparam int ITEMS_PER_SETTING = 220;
	localparam int NUM_SETTINGS = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;  // [0] button_level, [1] enable
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;  // [1:0] event_code
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]   cfg_data;

	int mismatches;
	int awaiting;
	int quiet_cycles = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	bit stall_go = 1'b0;

	int live_items = 0;
	int press_min_now;
	int hold_now;
	int window_now;

	// A negative entry means a random value is drawn for that setting.
	int press_min_list[NUM_SETTINGS] = '{0, 2, 254, 1, -1, 0, -1, 3, 1};
	int hold_list[NUM_SETTINGS]      = '{0, 12, 254, 8, -1, 254, -1, 15, 20};
	int window_list[NUM_SETTINGS]    = '{0, 4, 254, 3, -1, 0, -1, 6, 5};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	button_press_doublepress_hold_detector_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bpdh_event_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver stall while the sender keeps offering, so the block backs up.
	initial begin
		wait (stall_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic level, input logic en);
		item_t req;
		req.enable = en;
		req.button_level = level;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_W - $bits(item_t)){1'b0}}, req};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (en) begin
			live_items++;
		end
	endtask

	// Sends a run of one level with the odd disabled request mixed in.
	task automatic send_run(input logic level, input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 6) begin
				send_request(logic'($urandom_range(0, 1)), 1'b0);
			end
			send_request(level, 1'b1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CNT_W'(value);
		@(negedge clk);
	endtask

	task automatic run_gestures(input int budget);
		int goal;
		int pick;
		int press_len;
		int gap_len;
		int lo;
		int span;
		goal = live_items + budget;
		while (live_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 6)) begin
					send_request(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					press_len = $urandom_range(1, (press_min_now > 0) ? press_min_now : 1);
				end else if (pick < 82) begin
					lo = press_min_now + 1;
					span = hold_now - lo;
					if (span > 12 && $urandom_range(0, 3) != 0) begin
						span = 12;
					end
					press_len = (span >= 0) ? lo + $urandom_range(0, span) : lo;
				end else begin
					press_len = hold_now + 1 + $urandom_range(0, 2);
				end
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					gap_len = $urandom_range(1, (window_now > 0) ? window_now : 1);
				end else if (pick < 90) begin
					gap_len = window_now + 1 + $urandom_range(0, 2);
				end else begin
					gap_len = $urandom_range(1, 3);
				end
				send_run(1'b1, press_len);
				send_run(1'b0, gap_len);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset thresholds.
		send_request(1'b0, 1'b0);
		send_request(1'b1, 1'b0);
		// Single press, with a frozen request in the middle of it.
		send_request(1'b1, 1'b1);
		send_request(1'b1, 1'b1);
		send_request(1'b1, 1'b0);
		send_request(1'b1, 1'b1);
		repeat (6) send_request(1'b0, 1'b1);
		// Double press: release, press again within the window, release.
		send_request(1'b1, 1'b1);
		send_request(1'b1, 1'b1);
		send_request(1'b0, 1'b1);
		send_request(1'b1, 1'b1);
		send_request(1'b0, 1'b1);
		// A press too short to count clears everything.
		send_request(1'b1, 1'b1);
		send_request(1'b0, 1'b1);
		s_axis_tvalid <= 1'b0;

		for (int i = 0; i < NUM_SETTINGS; i++) begin
			wait_drained();
			press_min_now = (press_min_list[i] < 0) ? $urandom_range(0, 4) : press_min_list[i];
			hold_now = (hold_list[i] < 0) ? $urandom_range(3, 25) : hold_list[i];
			window_now = (window_list[i] < 0) ? $urandom_range(1, 8) : window_list[i];
			write_reg(CFG_PRESS_MIN, press_min_now);
			write_reg(CFG_HOLD, hold_now);
			write_reg(CFG_WINDOW, window_now);
			if (i == 0) begin
				// Writes to the unused index must leave the thresholds alone.
				write_reg(CFG_SPARE, $urandom_range(0, 255));
			end
			cfg_we <= 1'b0;
			case (i / 3)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			@(negedge clk);
			if (i == 6) begin
				stall_go = 1'b1;
			end
			run_gestures(ITEMS_PER_SETTING);
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/bpdh_pkg.sv
src/bpdh_cfg.sv
src/bpdh_detect.sv
src/button_press_doublepress_hold_detector_core.sv
tb/bpdh_event_checker.sv
tb/tb_top.sv
